// File: src/rbsi_pkg.sv
// Shared types and fixed latencies for the ray/box slab intersect core.
// Used by the axis lanes, the merge stage and the top level.
package rbsi_pkg;

   typedef struct packed {
      logic bounded;
      logic outside;
   } rbsi_flags_type;

   localparam int unsigned LANE_LAT  = 1;
   localparam int unsigned MERGE_LAT = 6;

endpackage

// File: src/rbsi_lane.sv
// One axis lane: entry and exit distances of the slab as fractions num/den.
// Depends on rbsi_pkg for the flag struct.
module rbsi_lane import rbsi_pkg::*; #(
   parameter int unsigned W = 32,
   parameter int unsigned F = 16
) (
   input  logic                clock,
   input  logic                en,
   input  logic signed [W-1:0] org,
   input  logic signed [W-1:0] dir,
   output logic signed [W:0]   en_num,
   output logic signed [W:0]   ex_num,
   output logic        [W-1:0] den,
   output rbsi_flags_type      flags
);

   localparam logic signed [W:0] ONE = (W+1)'(1) << F;

   logic signed [W:0] org_e, dir_e, dir_n;
   logic signed [W:0] en_num_ff, en_num_in, ex_num_ff, ex_num_in;
   logic [W-1:0]      den_ff, den_in;
   rbsi_flags_type    flags_ff, flags_in;

   always_comb begin
      org_e = {org[W-1], org};
      dir_e = {dir[W-1], dir};
      dir_n = -dir_e;
      flags_in.bounded = (dir != '0);
      flags_in.outside = (dir == '0) && ((org_e < -ONE) || (org_e > ONE));
      if (!dir[W-1]) begin
         en_num_in = -ONE - org_e;
         ex_num_in = ONE - org_e;
         den_in    = dir_e[W-1:0];
      end else begin
         en_num_in = org_e - ONE;
         ex_num_in = org_e + ONE;
         den_in    = dir_n[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         en_num_ff <= en_num_in;
         ex_num_ff <= ex_num_in;
         den_ff    <= den_in;
         flags_ff  <= flags_in;
      end
   end

   assign en_num = en_num_ff;
   assign ex_num = ex_num_ff;
   assign den    = den_ff;
   assign flags  = flags_ff;

endmodule

// File: src/rbsi_merge.sv
// Merge stage: latest entry and earliest exit over the three lanes, miss test
// and choice of the hit distance. Depends on rbsi_pkg.
module rbsi_merge import rbsi_pkg::*; #(
   parameter int unsigned W = 32
) (
   input  logic                clock,
   input  logic                en,
   input  logic signed [W:0]   en_num [3],
   input  logic signed [W:0]   ex_num [3],
   input  logic        [W-1:0] den    [3],
   input  rbsi_flags_type      flags  [3],
   output logic                hit,
   output logic signed [W:0]   t_num,
   output logic        [W-1:0] t_den
);

   localparam int unsigned PW = 2*W + 2;

   typedef struct packed {
      logic              bounded;
      logic signed [W:0] num;
      logic [W-1:0]      den;
   } dist_type;

   function automatic logic signed [PW-1:0] xmul(logic signed [W:0] n, logic [W-1:0] d);
      logic signed [PW-1:0] a, b;
      a = PW'(n);
      b = PW'($signed({1'b0, d}));
      return a * b;
   endfunction

   // stage 1: x against y products
   dist_type m1_tn_x_ff, m1_tn_y_ff, m1_tf_x_ff, m1_tf_y_ff, m1_tn_z_ff, m1_tf_z_ff;
   logic signed [PW-1:0] m1_pn_a_ff, m1_pn_b_ff, m1_pf_a_ff, m1_pf_b_ff;
   logic m1_out_ff;
   // stage 2: x/y winner
   dist_type m2_tn_ff, m2_tn_in, m2_tf_ff, m2_tf_in, m2_tn_z_ff, m2_tf_z_ff;
   logic m2_out_ff;
   // stage 3: winner against z products
   dist_type m3_tn_ff, m3_tf_ff, m3_tn_z_ff, m3_tf_z_ff;
   logic signed [PW-1:0] m3_pn_a_ff, m3_pn_b_ff, m3_pf_a_ff, m3_pf_b_ff;
   logic m3_out_ff;
   // stage 4: final interval
   dist_type m4_tn_ff, m4_tn_in, m4_tf_ff, m4_tf_in;
   logic m4_out_ff;
   // stage 5: entry against exit products
   dist_type m5_tn_ff, m5_tf_ff;
   logic signed [PW-1:0] m5_pa_ff, m5_pb_ff;
   logic m5_out_ff;
   // stage 6: decision
   logic hit_ff, hit_in;
   logic signed [W:0] t_num_ff, t_num_in;
   logic [W-1:0] t_den_ff, t_den_in;

   always_comb begin
      m2_tn_in = m1_tn_x_ff;
      if (m1_tn_y_ff.bounded && (!m1_tn_x_ff.bounded || (m1_pn_a_ff > m1_pn_b_ff)))
         m2_tn_in = m1_tn_y_ff;
      m2_tf_in = m1_tf_x_ff;
      if (m1_tf_y_ff.bounded && (!m1_tf_x_ff.bounded || (m1_pf_a_ff > m1_pf_b_ff)))
         m2_tf_in = m1_tf_y_ff;

      m4_tn_in = m3_tn_ff;
      if (m3_tn_z_ff.bounded && (!m3_tn_ff.bounded || (m3_pn_a_ff > m3_pn_b_ff)))
         m4_tn_in = m3_tn_z_ff;
      m4_tf_in = m3_tf_ff;
      if (m3_tf_z_ff.bounded && (!m3_tf_ff.bounded || (m3_pf_a_ff > m3_pf_b_ff)))
         m4_tf_in = m3_tf_z_ff;

      hit_in   = 1'b0;
      t_num_in = '0;
      t_den_in = W'(1);
      if (!m5_out_ff && !(m5_tn_ff.bounded && m5_tf_ff.bounded && (m5_pa_ff > m5_pb_ff))) begin
         if (m5_tn_ff.bounded && !m5_tn_ff.num[W]) begin
            hit_in   = 1'b1;
            t_num_in = m5_tn_ff.num;
            t_den_in = m5_tn_ff.den;
         end else if (!m5_tf_ff.bounded) begin
            hit_in = 1'b1;
         end else if (!m5_tf_ff.num[W]) begin
            hit_in   = 1'b1;
            t_num_in = m5_tf_ff.num;
            t_den_in = m5_tf_ff.den;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_tn_x_ff <= '{flags[0].bounded, en_num[0], den[0]};
         m1_tn_y_ff <= '{flags[1].bounded, en_num[1], den[1]};
         m1_tn_z_ff <= '{flags[2].bounded, en_num[2], den[2]};
         m1_tf_x_ff <= '{flags[0].bounded, ex_num[0], den[0]};
         m1_tf_y_ff <= '{flags[1].bounded, ex_num[1], den[1]};
         m1_tf_z_ff <= '{flags[2].bounded, ex_num[2], den[2]};
         m1_pn_a_ff <= xmul(en_num[1], den[0]);
         m1_pn_b_ff <= xmul(en_num[0], den[1]);
         m1_pf_a_ff <= xmul(ex_num[0], den[1]);
         m1_pf_b_ff <= xmul(ex_num[1], den[0]);
         m1_out_ff  <= flags[0].outside | flags[1].outside | flags[2].outside;

         m2_tn_ff   <= m2_tn_in;
         m2_tf_ff   <= m2_tf_in;
         m2_tn_z_ff <= m1_tn_z_ff;
         m2_tf_z_ff <= m1_tf_z_ff;
         m2_out_ff  <= m1_out_ff;

         m3_tn_ff   <= m2_tn_ff;
         m3_tf_ff   <= m2_tf_ff;
         m3_tn_z_ff <= m2_tn_z_ff;
         m3_tf_z_ff <= m2_tf_z_ff;
         m3_pn_a_ff <= xmul(m2_tn_z_ff.num, m2_tn_ff.den);
         m3_pn_b_ff <= xmul(m2_tn_ff.num, m2_tn_z_ff.den);
         m3_pf_a_ff <= xmul(m2_tf_ff.num, m2_tf_z_ff.den);
         m3_pf_b_ff <= xmul(m2_tf_z_ff.num, m2_tf_ff.den);
         m3_out_ff  <= m2_out_ff;

         m4_tn_ff  <= m4_tn_in;
         m4_tf_ff  <= m4_tf_in;
         m4_out_ff <= m3_out_ff;

         m5_tn_ff  <= m4_tn_ff;
         m5_tf_ff  <= m4_tf_ff;
         m5_pa_ff  <= xmul(m4_tn_ff.num, m4_tf_ff.den);
         m5_pb_ff  <= xmul(m4_tf_ff.num, m4_tn_ff.den);
         m5_out_ff <= m4_out_ff;

         hit_ff   <= hit_in;
         t_num_ff <= t_num_in;
         t_den_ff <= t_den_in;
      end
   end

   assign hit   = hit_ff;
   assign t_num = t_num_ff;
   assign t_den = t_den_ff;

endmodule

// File: src/rbsi_impact.sv
// One impact coordinate: org + trunc(num*dir/den), pipelined restoring divide
// one quotient bit per stage, then saturation. Stand-alone, no package types.
module rbsi_impact #(
   parameter int unsigned W = 32
) (
   input  logic                clock,
   input  logic                en,
   input  logic                hit,
   input  logic signed [W:0]   t_num,
   input  logic        [W-1:0] t_den,
   input  logic signed [W-1:0] org,
   input  logic signed [W-1:0] dir,
   output logic signed [W-1:0] impact
);

   localparam int unsigned PW = 2*W + 2;
   localparam int unsigned RW = 2*W + 1;
   localparam int unsigned NS = W + 1;
   localparam logic signed [W+2:0] SMAX = (W+3)'((W+3)'(1) << (W-1)) - (W+3)'(1);
   localparam logic signed [W+2:0] SMIN = -SMAX - (W+3)'(1);

   logic signed [PW-1:0] p_ff, p_neg;
   logic [W-1:0] p_den_ff;
   logic signed [W-1:0] p_org_ff;
   logic p_hit_ff;

   logic [RW-1:0] r_ff [NS+1];
   logic [NS-1:0] q_ff [NS+1];
   logic [W-1:0]  d_ff [NS+1];
   logic signed [W-1:0] o_ff [NS+1];
   logic neg_ff [NS+1];
   logic ovf_ff [NS+1];
   logic h_ff   [NS+1];

   logic signed [W+2:0] sum;
   logic signed [W-1:0] impact_ff, impact_in;

   assign p_neg = -p_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff     <= PW'(t_num) * PW'(dir);
         p_den_ff <= t_den;
         p_org_ff <= org;
         p_hit_ff <= hit;
         r_ff[0]   <= p_ff[PW-1] ? p_neg[RW-1:0] : p_ff[RW-1:0];
         ovf_ff[0] <= (p_ff[PW-1] ? p_neg[RW-1:0] : p_ff[RW-1:0])
                      >= (RW'(p_den_ff) << NS);
         neg_ff[0] <= p_ff[PW-1];
         q_ff[0]   <= '0;
         d_ff[0]   <= p_den_ff;
         o_ff[0]   <= p_org_ff;
         h_ff[0]   <= p_hit_ff;
      end
   end

   for (genvar k = 0; k < NS; k++) begin : g_div
      localparam int unsigned SH = NS - 1 - k;
      logic [RW-1:0] sub;
      logic          take;
      assign sub  = RW'(d_ff[k]) << SH;
      assign take = r_ff[k] >= sub;
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k+1]   <= take ? (r_ff[k] - sub) : r_ff[k];
            q_ff[k+1]   <= q_ff[k] | (take ? (NS'(1) << SH) : '0);
            d_ff[k+1]   <= d_ff[k];
            o_ff[k+1]   <= o_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
            h_ff[k+1]   <= h_ff[k];
         end
      end
   end

   always_comb begin
      sum = (W+3)'(o_ff[NS]) + (neg_ff[NS] ? -(W+3)'(q_ff[NS]) : (W+3)'(q_ff[NS]));
      if (!h_ff[NS])
         impact_in = '0;
      else if (ovf_ff[NS])
         impact_in = neg_ff[NS] ? SMIN[W-1:0] : SMAX[W-1:0];
      else if (sum > SMAX)
         impact_in = SMAX[W-1:0];
      else if (sum < SMIN)
         impact_in = SMIN[W-1:0];
      else
         impact_in = sum[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en)
         impact_ff <= impact_in;
   end

   assign impact = impact_ff;

endmodule

// File: src/ray_box_slab_intersect_core.sv
// Top level of the ray against unit cube slab test core.
// Depends on rbsi_pkg, rbsi_lane, rbsi_merge and rbsi_impact.
//
// Usage: one ray word enters on the req_ stream (origin xyz, direction xyz,
// signed fixed point), one result word leaves on the rsp_ stream: the hit
// flag in rsp_tuser and the impact point in rsp_tdata, zero on a miss.
// Three axis lanes form entry/exit fractions, a merge stage intersects the
// intervals, and three impact units multiply and divide out the point.
// The pipeline holds one lane stage, six merge stages, one product stage,
// one range check, one stage per quotient bit of each restoring divider and
// one output register. Throughput is one word per cycle while no stall
// holds it; the whole pipeline moves on one enable.
// When rsp_tready is low while a result is shown, the pipeline holds and
// req_tready drops in the same cycle. Synchronous reset clears all valid
// bits; payload registers keep stale data that is never shown.
module ray_box_slab_intersect_core import rbsi_pkg::*; #(
   parameter int unsigned COORD_WIDTH = 32,
   parameter int unsigned FRAC_BITS   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
   input  logic [((6*COORD_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // impact_x, impact_y, impact_z
   output logic [((3*COORD_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
   // hit
   output logic                  rsp_tuser
);

   localparam int unsigned W       = COORD_WIDTH;
   localparam int unsigned REQ_TW  = ((6*COORD_WIDTH + 7) / 8) * 8;
   localparam int unsigned RSP_TW  = ((3*COORD_WIDTH + 7) / 8) * 8;
   localparam int unsigned PRE_LAT = LANE_LAT + MERGE_LAT;
   localparam int unsigned IMP_LAT = W + 4;
   localparam int unsigned TOT_LAT = PRE_LAT + IMP_LAT;

   logic en;
   logic [TOT_LAT-1:0] valid_ff;
   logic [6*W-1:0] ray_ff [PRE_LAT];
   logic [IMP_LAT-1:0] hit_ff;

   logic signed [W:0]   en_num [3];
   logic signed [W:0]   ex_num [3];
   logic        [W-1:0] den    [3];
   rbsi_flags_type      flags  [3];
   logic                m_hit;
   logic signed [W:0]   t_num;
   logic        [W-1:0] t_den;
   logic signed [W-1:0] impact [3];

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= '0;
      else if (en)
         valid_ff <= {valid_ff[TOT_LAT-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ray_ff[0] <= req_tdata[6*W-1:0];
         for (int i = 1; i < PRE_LAT; i++)
            ray_ff[i] <= ray_ff[i-1];
         hit_ff <= {hit_ff[IMP_LAT-2:0], m_hit};
      end
   end

   for (genvar a = 0; a < 3; a++) begin : g_axis
      rbsi_lane #(.W(W), .F(FRAC_BITS)) u_lane (
         .clock (clock),
         .en    (en),
         .org   (req_tdata[a*W +: W]),
         .dir   (req_tdata[(a+3)*W +: W]),
         .en_num(en_num[a]),
         .ex_num(ex_num[a]),
         .den   (den[a]),
         .flags (flags[a])
      );

      rbsi_impact #(.W(W)) u_impact (
         .clock (clock),
         .en    (en),
         .hit   (m_hit),
         .t_num (t_num),
         .t_den (t_den),
         .org   (ray_ff[PRE_LAT-1][a*W +: W]),
         .dir   (ray_ff[PRE_LAT-1][(a+3)*W +: W]),
         .impact(impact[a])
      );
   end

   rbsi_merge #(.W(W)) u_merge (
      .clock (clock),
      .en    (en),
      .en_num(en_num),
      .ex_num(ex_num),
      .den   (den),
      .flags (flags),
      .hit   (m_hit),
      .t_num (t_num),
      .t_den (t_den)
   );

   assign rsp_tvalid = valid_ff[TOT_LAT-1];
   assign rsp_tuser  = hit_ff[IMP_LAT-1];
   assign rsp_tdata  = RSP_TW'({impact[2], impact[1], impact[0]});

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss word carries a nonzero impact point");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> valid_ff[0])
      else $error("accepted word did not enter the pipeline");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(valid_ff) && $stable(rsp_tuser))
      else $error("pipeline moved during a stall");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && valid_ff == '0)
      else $error("reset left a word in flight");

endmodule

// File: tb/sv/tb.sv
// Testbench for ray_box_slab_intersect_core: directed and random rays with a
// stream-side predictor of the slab test. Depends on rbsi_pkg and the core RTL.
module tb;
   import rbsi_pkg::*;

   localparam int ONE = 65536;
   localparam int IMAX = 32'h7fffffff;
   localparam int IMIN = 32'h80000000;
   localparam int N_RANDOM = 530;

   typedef struct {
      int ox, oy, oz, dx, dy, dz;
   } ray_t;

   typedef struct {
      bit hit;
      int ix, iy, iz;
   } impact_t;

   typedef struct {
      ray_t r;
      bit typed;
      impact_t e;
   } row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [191:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic rsp_tuser;

   impact_t pending_impacts[$];
   int mismatch_count = 0;
   bit sending_done = 1'b0;

   ray_box_slab_intersect_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic impact_t slab_impact(ray_t r);
      longint o[3], d[3];
      longint nn, nd, fn, fd, an, af, ad, tnum, tden, s;
      bit nb, fb;
      impact_t res;
      o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
      d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
      res = '{0, 0, 0, 0};
      nb = 0; fb = 0; nn = 0; nd = 1; fn = 0; fd = 1;
      for (int i = 0; i < 3; i++) begin
         if (d[i] == 0) begin
            if (o[i] < -ONE || o[i] > ONE) return res;
            continue;
         end
         if (d[i] > 0) begin
            an = -ONE - o[i]; af = ONE - o[i]; ad = d[i];
         end else begin
            an = o[i] - ONE; af = o[i] + ONE; ad = -d[i];
         end
         if (!nb || an * nd > nn * ad) begin
            nb = 1; nn = an; nd = ad;
         end
         if (!fb || fn * ad > af * fd) begin
            fb = 1; fn = af; fd = ad;
         end
         if (nn * fd > fn * nd) return res;
      end
      if (nb && nn >= 0) begin
         tnum = nn; tden = nd;
      end else if (!fb) begin
         tnum = 0; tden = 1;
      end else if (fn >= 0) begin
         tnum = fn; tden = fd;
      end else begin
         return res;
      end
      res.hit = 1;
      for (int i = 0; i < 3; i++) begin
         s = o[i] + (tnum * d[i]) / tden;
         if (s > longint'(IMAX)) s = IMAX;
         if (s < longint'(IMIN)) s = IMIN;
         if (i == 0) res.ix = int'(s);
         else if (i == 1) res.iy = int'(s);
         else res.iz = int'(s);
      end
      return res;
   endfunction

   function automatic ray_t random_ray();
      ray_t r;
      int mode, tx, ty, tz, sh;
      mode = $urandom_range(0, 9);
      r.ox = $urandom; r.oy = $urandom; r.oz = $urandom;
      r.dx = $urandom; r.dy = $urandom; r.dz = $urandom;
      if (mode <= 5) begin
         r.ox = $urandom_range(0, 8 * ONE) - 4 * ONE;
         r.oy = $urandom_range(0, 8 * ONE) - 4 * ONE;
         r.oz = $urandom_range(0, 8 * ONE) - 4 * ONE;
         tx = $urandom_range(0, 2 * ONE + 2000) - ONE - 1000;
         ty = $urandom_range(0, 2 * ONE + 2000) - ONE - 1000;
         tz = $urandom_range(0, 2 * ONE + 2000) - ONE - 1000;
         sh = $urandom_range(0, 6);
         r.dx = (tx - r.ox) <<< sh; r.dy = (ty - r.oy) <<< sh; r.dz = (tz - r.oz) <<< sh;
         if (mode == 5) begin
            r.dx = -r.dx; r.dy = -r.dy; r.dz = -r.dz;
         end
      end else if (mode == 7) begin
         if ($urandom_range(0, 1)) r.dx = 0;
         if ($urandom_range(0, 1)) r.dy = 0;
         if ($urandom_range(0, 1)) r.dz = 0;
         if ($urandom_range(0, 1)) r.ox = $urandom_range(0, 2 * ONE + 2) - ONE - 1;
         if ($urandom_range(0, 1)) r.oy = $urandom_range(0, 2 * ONE + 2) - ONE - 1;
         if ($urandom_range(0, 1)) r.oz = $urandom_range(0, 2 * ONE + 2) - ONE - 1;
      end else if (mode == 8) begin
         r.ox = $urandom_range(0, 2 * ONE) - ONE;
         r.oy = $urandom_range(0, 2 * ONE) - ONE;
         r.oz = $urandom_range(0, 2 * ONE) - ONE;
      end else if (mode == 9) begin
         r.dx = $urandom_range(0, 8) - 4;
         r.dy = $urandom_range(0, 8) - 4;
         r.dz = $urandom_range(0, 8) - 4;
      end
      return r;
   endfunction

   // receiver stall pattern: phases of always-ready, coin flips and long stalls
   int stall_phase = 0;
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_phase <= $urandom_range(0, 2);
         stall_left <= $urandom_range(10, 80);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_phase)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= $urandom_range(0, 1);
         default: rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(negedge clock) begin
      impact_t e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_impacts.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected word: hit %0d", rsp_tuser);
         end else begin
            e = pending_impacts.pop_front();
            if (rsp_tuser !== e.hit || rsp_tdata[31:0] !== e.ix
                || rsp_tdata[63:32] !== e.iy || rsp_tdata[95:64] !== e.iz) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("expected hit %0d (%0d %0d %0d), got hit %0d (%0d %0d %0d)",
                           e.hit, e.ix, e.iy, e.iz, rsp_tuser,
                           $signed(rsp_tdata[31:0]), $signed(rsp_tdata[63:32]),
                           $signed(rsp_tdata[95:64]));
            end
         end
      end
   end

   task automatic send_ray(ray_t r, bit typed, impact_t e);
      req_tvalid <= 1'b1;
      req_tdata <= {r.dz, r.dy, r.dx, r.oz, r.oy, r.ox};
      forever begin
         @(negedge clock);
         if (req_tready) break;
         @(posedge clock);
      end
      pending_impacts.push_back(typed ? e : slab_impact(r));
      @(posedge clock);
   endtask

   row_t steer_rows[] = '{
      '{'{0, 0, 0, 0, 0, 0}, 1, '{1, 0, 0, 0}},
      '{'{2 * ONE, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 0}},
      '{'{0, 0, -2 * ONE, 0, 0, ONE}, 1, '{1, 0, 0, -ONE}},
      '{'{0, 0, 2 * ONE, 0, 0, ONE}, 1, '{0, 0, 0, 0}},
      '{'{ONE, -ONE, 0, 0, 0, 0}, 1, '{1, ONE, -ONE, 0}},
      '{'{ONE + 1, 0, 0, 0, ONE, 0}, 1, '{0, 0, 0, 0}},
      '{'{-2 * ONE, ONE, 0, ONE, 0, 0}, 1, '{1, -ONE, ONE, 0}},
      '{'{-2 * ONE, -2 * ONE, 0, ONE, ONE, 0}, 1, '{1, -ONE, -ONE, 0}},
      '{'{0, 0, 0, ONE, 0, 0}, 1, '{1, ONE, 0, 0}},
      '{'{-2 * ONE, 0, 0, ONE, 2 * ONE, 0}, 0, '{0, 0, 0, 0}},
      '{'{IMAX, IMAX, IMAX, IMIN, IMIN, IMIN}, 0, '{0, 0, 0, 0}},
      '{'{IMIN, IMIN, IMIN, IMAX, IMAX, IMAX}, 0, '{0, 0, 0, 0}},
      '{'{IMAX, IMAX, IMAX, IMAX, IMAX, IMAX}, 0, '{0, 0, 0, 0}},
      '{'{IMIN, IMIN, IMIN, IMIN, IMIN, IMIN}, 0, '{0, 0, 0, 0}},
      '{'{0, 0, 0, IMAX, IMIN, 1}, 0, '{0, 0, 0, 0}},
      '{'{-1, -1, -1, 1, -1, 1}, 0, '{0, 0, 0, 0}},
      '{'{0, 0, -3 * ONE, 1, 2, 3}, 0, '{0, 0, 0, 0}},
      '{'{IMIN, 0, 0, 1, 0, 0}, 0, '{0, 0, 0, 0}},
      '{'{0, IMAX, 0, 0, -1, 0}, 0, '{0, 0, 0, 0}},
      '{'{-ONE, -ONE, -ONE, -1, -1, -1}, 0, '{0, 0, 0, 0}}
   };

   initial begin
      impact_t none;
      int burst;
      none = '{0, 0, 0, 0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (steer_rows[i]) send_ray(steer_rows[i].r, steer_rows[i].typed, steer_rows[i].e);
      burst = 0;
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM / 2) begin
            req_tvalid <= 1'b0;
            while (pending_impacts.size() != 0) @(posedge clock);
         end else if (burst <= 0) begin
            burst = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
               req_tvalid <= 1'b0;
               repeat ($urandom_range(1, 12)) @(posedge clock);
            end
         end
         burst--;
         send_ray(random_ray(), 0, none);
      end
      req_tvalid <= 1'b0;
      while (pending_impacts.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && pending_impacts.size() == 0)
         $display("ray_box_slab_intersect_core: match");
      else
         $display("ray_box_slab_intersect_core: mismatch");
      $finish;
   end

   initial begin
      #5000000;
      $display("ray_box_slab_intersect_core: mismatch");
      $finish;
   end

endmodule
